[hdl/wbps_pkg.sv]
// wbps_pkg: shared types and constants for the wildcard byte pattern search
// item structs, stage control struct, configuration register indexes
// no dependencies
package wbps_pkg;

    localparam int REG_BYTES  = 32;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_OFF_W  = 32;

    localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0_7   = 3'd0,
        CFG_PATTERN_8_15  = 3'd1,
        CFG_PATTERN_16_23 = 3'd2,
        CFG_PATTERN_24_31 = 3'd3,
        CFG_PATTERN_LEN   = 3'd4,
        CFG_MATCH_MODE    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] match_offset;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic last;
    } wbps_ctl_t;

endpackage

[hdl/wbps_window.sv]
// wbps_window: input stage, shifts accepted bytes into the window register
// and keeps the saturating byte position counter
// depends on wbps_pkg
module wbps_window
    import wbps_pkg::*;
#(
    parameter int WIN         = 32,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  in_item_t                       in_data,
    input  logic                           take,
    output wbps_ctl_t                      ctl,
    output logic [WIN-1:0][BYTE_W-1:0]     window,
    output logic [OFFSET_BITS-1:0]         byte_idx
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    wbps_ctl_t                      ctl_reg, ctl_next;
    logic [WIN-1:0][BYTE_W-1:0]     window_reg, window_next;
    logic [OFFSET_BITS-1:0]         pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]         idx_reg, idx_next;
    logic                           accept;

    assign in_stall = ctl_reg.valid && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ctl_next    = ctl_reg;
        window_next = window_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        if (accept)
        begin
            ctl_next.valid = 1'b1;
            ctl_next.last  = in_data.last_byte;
            if (WIN > 1)
            begin
                for (int i = WIN - 1; i > 0; i--)
                begin
                    window_next[i] = window_reg[i-1];
                end
            end
            window_next[0] = in_data.data_byte;
            idx_next       = pos_reg;
            if (in_data.last_byte)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (take)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        idx_reg    <= idx_next;
    end

    assign ctl      = ctl_reg;
    assign window   = window_reg;
    assign byte_idx = idx_reg;

endmodule

[hdl/wbps_match.sv]
// wbps_match: compare stage, matches the window against the pattern,
// tracks the recorded match and holds the result register
// depends on wbps_pkg
module wbps_match
    import wbps_pkg::*;
#(
    parameter int WIN         = 32,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  wbps_ctl_t                      ctl,
    input  logic [WIN-1:0][BYTE_W-1:0]     window,
    input  logic [OFFSET_BITS-1:0]         byte_idx,
    input  logic [WIN-1:0][BYTE_W-1:0]     pattern,
    input  logic [LEN_W-1:0]               len,
    input  logic                           match_mode,
    output logic                           take,
    output logic                           out_valid,
    input  logic                           out_stall,
    output out_item_t                      out_data
);

    localparam int WIN_IDX_W = (WIN > 1) ? $clog2(WIN) : 1;

    logic                       seen_reg, seen_next;
    logic [OFFSET_BITS-1:0]     start_reg, start_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;
    logic [WIN-1:0]             byte_ok;
    logic                       hit;
    logic                       in_range;
    logic [OFFSET_BITS:0]       idx_plus;
    logic [OFFSET_BITS-1:0]     start_pos;
    logic                       rec_seen;
    logic [OFFSET_BITS-1:0]     rec_start;

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            logic [LEN_W-1:0] sel;
            sel = len - 1'b1 - LEN_W'(i);
            byte_ok[i] = (LEN_W'(i) >= len) || (pattern[i] == WILDCARD_BYTE)
                         || (pattern[i] == window[sel[WIN_IDX_W-1:0]]);
        end
    end

    assign idx_plus  = {1'b0, byte_idx} + 1'b1;
    assign in_range  = idx_plus >= (OFFSET_BITS+1)'(len);
    assign start_pos = OFFSET_BITS'(idx_plus - (OFFSET_BITS+1)'(len));
    assign hit       = in_range && (&byte_ok);

    assign take = ctl.valid && !(ctl.last && out_valid_reg && out_stall);

    always_comb
    begin
        rec_seen  = seen_reg;
        rec_start = start_reg;
        if (hit && (match_mode || !seen_reg))
        begin
            rec_seen  = 1'b1;
            rec_start = start_pos;
        end
    end

    always_comb
    begin
        seen_next      = seen_reg;
        start_next     = start_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (take)
        begin
            if (ctl.last)
            begin
                seen_next                  = 1'b0;
                start_next                 = '0;
                out_valid_next             = 1'b1;
                out_data_next.found        = rec_seen;
                out_data_next.match_offset = rec_seen ? OUT_OFF_W'(rec_start) : '0;
            end
            else
            begin
                seen_next  = rec_seen;
                start_next = rec_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ctl.last) |=> out_valid_reg)
        else $error("result missing after last byte");

    a_blocked_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.valid && ctl.last && !take) |=> (ctl.valid && ctl.last))
        else $error("blocked last byte lost");

    a_no_match_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |-> (out_data_reg.match_offset == '0))
        else $error("offset nonzero without match");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (start_reg == '0))
        else $error("recorded start without match");

endmodule

[hdl/wildcard_byte_pattern_search.sv]
// wildcard_byte_pattern_search: top level, configuration registers and the
// window and compare stages
// depends on wbps_pkg, wbps_window, wbps_match
//
//  channel  | signals                             | transaction
//  ---------+-------------------------------------+---------------------------
//  in       | in_valid, in_stall, in_data         | one byte, last-byte mark
//  out      | out_valid, out_stall, out_data      | found and offset, per region
//  cfg      | cfg_write, cfg_index, cfg_data      | one register write
//
// one byte per cycle while in_stall is low; a byte goes window register -> compare ->
// result register, so the result follows the last byte through both registers
// reset clears the position counter, match record and pipeline valids
// a stalled result holds the compare stage only when it carries a last byte
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int WIN = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int WORD_BYTES = CFG_DATA_W / BYTE_W;

    logic [REG_BYTES-1:0][BYTE_W-1:0]   pattern_reg, pattern_next;
    logic [LEN_W-1:0]                   length_reg, length_next;
    logic                               mode_reg, mode_next;
    logic [LEN_W-1:0]                   len_eff;
    wbps_ctl_t                          ctl;
    logic [WIN-1:0][BYTE_W-1:0]         window;
    logic [OFFSET_BITS-1:0]             byte_idx;
    logic                               take;

    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        mode_next    = mode_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_0_7:   pattern_next[0*WORD_BYTES +: WORD_BYTES] = cfg_data;
                CFG_PATTERN_8_15:  pattern_next[1*WORD_BYTES +: WORD_BYTES] = cfg_data;
                CFG_PATTERN_16_23: pattern_next[2*WORD_BYTES +: WORD_BYTES] = cfg_data;
                CFG_PATTERN_24_31: pattern_next[3*WORD_BYTES +: WORD_BYTES] = cfg_data;
                CFG_PATTERN_LEN:   length_next = cfg_data[LEN_W-1:0];
                CFG_MATCH_MODE:    mode_next   = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            mode_reg    <= 1'b0;
        end
        else
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            mode_reg    <= mode_next;
        end
    end

    always_comb
    begin
        if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(WIN))
        begin
            len_eff = LEN_W'(WIN);
        end
        else
        begin
            len_eff = length_reg;
        end
    end

    wbps_window #(
        .WIN         (WIN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .take     (take),
        .ctl      (ctl),
        .window   (window),
        .byte_idx (byte_idx)
    );

    wbps_match #(
        .WIN         (WIN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .window     (window),
        .byte_idx   (byte_idx),
        .pattern    (pattern_reg[WIN-1:0]),
        .len        (len_eff),
        .match_mode (mode_reg),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
